// ===== rtl/core/mcfe_pkg.sv =====
`default_nettype none

package mcfe_pkg;

    // pipeline depth, one register per stage
    localparam int NST = 8;

    // fixed-point width of the offset sum, 50 fraction bits
    localparam int FW = 60;

    // command selector codes
    localparam logic [2:0] FN_MIT     = 3'd0;
    localparam logic [2:0] FN_POSVEL  = 3'd1;
    localparam logic [2:0] FN_VEL     = 3'd2;
    localparam logic [2:0] FN_ENABLE  = 3'd3;
    localparam logic [2:0] FN_DISABLE = 3'd4;
    localparam logic [2:0] FN_ZERO    = 3'd5;

    // identifier offsets and command bytes
    localparam logic [10:0] ID_OFS_POSVEL = 11'h100;
    localparam logic [10:0] ID_OFS_VEL    = 11'h200;
    localparam logic [7:0]  CMD_FILL      = 8'hFF;
    localparam logic [7:0]  CMD_ENABLE    = 8'hFC;
    localparam logic [7:0]  CMD_DISABLE   = 8'hFD;
    localparam logic [7:0]  CMD_ZERO      = 8'hFE;

    // reciprocals floor(2^s / d) for the odd part of each span
    localparam logic [31:0] RC_25  = 32'((64'd1 << 36) / 64'd25);
    localparam logic [31:0] RC_45  = 32'((64'd1 << 37) / 64'd45);
    localparam logic [31:0] RC_125 = 32'((64'd1 << 38) / 64'd125);
    localparam logic [31:0] RC_5   = 32'((64'd1 << 34) / 64'd5);

    // per-channel quantizer constants
    typedef struct packed {
        logic          signed_range;  // range is -lim..lim, else 0..lim
        logic [30:0]   lim_mag;       // float magnitude bits of the limit
        logic [FW-1:0] off_fix;       // -lo in fixed point
        logic [15:0]   top;           // 2^b - 1
        logic [6:0]    div;           // odd part of the span
        logic [1:0]    span_sh;       // power-of-two part of the span
        logic [31:0]   recip;         // reciprocal of div
        logic [5:0]    recip_sh;      // reciprocal scale exponent
    } t_qcfg;

    localparam t_qcfg QC_POS = '{
        signed_range: 1'b1, lim_mag: 31'h41480000, off_fix: FW'(25) << 49,
        top: 16'hFFFF, div: 7'd25, span_sh: 2'd0, recip: RC_25, recip_sh: 6'd36};
    localparam t_qcfg QC_VEL = '{
        signed_range: 1'b1, lim_mag: 31'h42340000, off_fix: FW'(45) << 50,
        top: 16'h0FFF, div: 7'd45, span_sh: 2'd1, recip: RC_45, recip_sh: 6'd37};
    localparam t_qcfg QC_KP = '{
        signed_range: 1'b0, lim_mag: 31'h43FA0000, off_fix: '0,
        top: 16'h0FFF, div: 7'd125, span_sh: 2'd2, recip: RC_125, recip_sh: 6'd38};
    localparam t_qcfg QC_KD = '{
        signed_range: 1'b0, lim_mag: 31'h40A00000, off_fix: '0,
        top: 16'h0FFF, div: 7'd5, span_sh: 2'd0, recip: RC_5, recip_sh: 6'd34};
    localparam t_qcfg QC_TQ = '{
        signed_range: 1'b1, lim_mag: 31'h41200000, off_fix: FW'(10) << 50,
        top: 16'h0FFF, div: 7'd5, span_sh: 2'd2, recip: RC_5, recip_sh: 6'd34};

    // frame data that does not need quantizing, carried beside the quantizers
    typedef struct packed {
        logic            mit;
        logic [10:0]     id;
        logic [7:0][7:0] data;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/core/mcfe_quant.sv =====
`default_nettype none

module mcfe_quant (
    input  wire                    i_clk,
    input  wire mcfe_pkg::t_qcfg   i_cfg,
    input  wire [mcfe_pkg::NST-1:0] i_load,
    input  wire [31:0]             i_bits,
    output logic [15:0]            o_code
);
    import mcfe_pkg::*;

    // stage 0: clamp, convert to fixed point, add offset
    logic          is_nan;
    logic          cs;
    logic [30:0]   cm;
    logic [23:0]   mant;
    logic [7:0]    ex;
    logic [7:0]    rsh0;
    logic [FW-1:0] xf;
    logic [FW-1:0] n_s;
    logic [FW-1:0] r_s;

    always_comb begin
        is_nan = (i_bits[30:23] == 8'hFF) && (i_bits[22:0] != 23'd0);
        cs     = i_bits[31];
        cm     = i_bits[30:0];
        if (i_cfg.signed_range) begin
            if (is_nan) begin
                cs = 1'b1;
                cm = i_cfg.lim_mag;
            end else if (i_bits[30:0] > i_cfg.lim_mag) begin
                cm = i_cfg.lim_mag;
            end
        end else begin
            if (is_nan || i_bits[31]) begin
                cs = 1'b0;
                cm = '0;
            end else if (i_bits[30:0] > i_cfg.lim_mag) begin
                cm = i_cfg.lim_mag;
            end
        end
        mant = {1'b1, cm[22:0]};
        ex   = cm[30:23];
        rsh0 = 8'd100 - ex;
        if (ex < 8'd87) begin
            xf = '0;
        end else if (ex >= 8'd100) begin
            xf = FW'(mant) << (ex - 8'd100);
        end else begin
            xf = FW'(mant >> rsh0) | FW'(|(mant & ~(24'hFFFFFF << rsh0)));
        end
        n_s = cs ? (i_cfg.off_fix - xf) : (i_cfg.off_fix + xf);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) r_s <= n_s;
    end

    // stage 1: round the difference to single precision
    logic [5:0]  p1;
    logic [5:0]  n_kd;
    logic [23:0] kept1;
    logic        g1;
    logic        st1;
    logic [24:0] n_md;
    logic [24:0] r_md;
    logic [5:0]  r_kd;

    always_comb begin
        p1 = '0;
        for (int i = 0; i < FW; i++) begin
            if (r_s[i]) p1 = 6'(i);
        end
        kept1 = '0;
        g1    = 1'b0;
        st1   = 1'b0;
        if (p1 <= 6'd23) begin
            n_kd = '0;
            n_md = {1'b0, r_s[23:0]};
        end else begin
            n_kd  = p1 - 6'd23;
            kept1 = 24'(r_s >> n_kd);
            g1    = r_s[6'(n_kd - 6'd1)];
            st1   = |(r_s & ((FW'(1) << (n_kd - 6'd1)) - FW'(1)));
            n_md  = {1'b0, kept1} + 25'(g1 & (st1 | kept1[0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_md <= n_md;
            r_kd <= n_kd;
        end
    end

    // stage 2: scale by 2^b - 1
    logic [40:0] r_p;
    logic [5:0]  r_kd2;

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_p   <= 41'(r_md) * 41'(i_cfg.top);
            r_kd2 <= r_kd;
        end
    end

    // stage 3: round the product, normalize to 24 bits
    logic [5:0]        lp;
    logic [5:0]        sh3;
    logic [23:0]       kept3;
    logic              g3;
    logic              st3;
    logic [24:0]       sum3;
    logic [23:0]       n_mm;
    logic signed [7:0] n_em;
    logic [23:0]       r_mm;
    logic signed [7:0] r_em3;
    logic              r_zero3;

    always_comb begin
        lp = '0;
        for (int i = 0; i < 41; i++) begin
            if (r_p[i]) lp = 6'(i);
        end
        sh3   = '0;
        kept3 = '0;
        g3    = 1'b0;
        st3   = 1'b0;
        sum3  = '0;
        if (lp >= 6'd24) begin
            sh3   = lp - 6'd23;
            kept3 = 24'(r_p >> sh3);
            g3    = r_p[6'(sh3 - 6'd1)];
            st3   = |(r_p & ((41'd1 << (sh3 - 6'd1)) - 41'd1));
            sum3  = {1'b0, kept3} + 25'(g3 & (st3 | kept3[0]));
            if (sum3[24]) begin
                n_mm = 24'h800000;
                n_em = 8'(int'(r_kd2) + int'(sh3) + 1);
            end else begin
                n_mm = sum3[23:0];
                n_em = 8'(int'(r_kd2) + int'(sh3));
            end
        end else begin
            n_mm = 24'(r_p << (6'd23 - lp));
            n_em = 8'(int'(r_kd2) + int'(lp) - 23);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r_mm    <= n_mm;
            r_em3   <= n_em;
            r_zero3 <= (r_p == 41'd0);
        end
    end

    // stage 4: quotient estimate by reciprocal multiply
    logic [31:0]       n4;
    logic [63:0]       prod4;
    logic [31:0]       r_n;
    logic [29:0]       r_qe;
    logic signed [7:0] r_em4;
    logic              r_zero4;

    always_comb begin
        n4    = {r_mm, 8'h00};
        prod4 = 64'(n4) * 64'(i_cfg.recip);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r_n     <= n4;
            r_qe    <= 30'(prod4 >> i_cfg.recip_sh);
            r_em4   <= r_em3;
            r_zero4 <= r_zero3;
        end
    end

    // stage 5: remainder and one correction step
    logic [36:0]       qd;
    logic [36:0]       rem;
    logic [29:0]       n_q;
    logic              n_st;
    logic [29:0]       r_q;
    logic              r_st;
    logic signed [7:0] r_em5;
    logic              r_zero5;

    always_comb begin
        qd = 37'(r_qe) * 37'(i_cfg.div);
        rem = 37'(r_n) - qd;
        if (rem >= 37'(i_cfg.div)) begin
            n_q  = r_qe + 30'd1;
            n_st = (rem - 37'(i_cfg.div)) != 37'd0;
        end else begin
            n_q  = r_qe;
            n_st = rem != 37'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r_q     <= n_q;
            r_st    <= n_st;
            r_em5   <= r_em4;
            r_zero5 <= r_zero4;
        end
    end

    // stage 6: round the quotient to single precision
    logic [4:0]        lq;
    logic [4:0]        rsh6;
    logic [23:0]       kept6;
    logic              g6;
    logic              st6;
    logic [24:0]       n_qr;
    logic signed [8:0] n_fe;
    logic [24:0]       r_qr;
    logic signed [8:0] r_fe;
    logic              r_zero6;

    always_comb begin
        lq = '0;
        for (int i = 0; i < 30; i++) begin
            if (r_q[i]) lq = 5'(i);
        end
        kept6 = '0;
        g6    = 1'b0;
        st6   = 1'b0;
        if (lq <= 5'd23) begin
            rsh6 = '0;
            n_qr = {1'b0, r_q[23:0]};
        end else begin
            rsh6  = lq - 5'd23;
            kept6 = 24'(r_q >> rsh6);
            g6    = r_q[5'(rsh6 - 5'd1)];
            st6   = (|(r_q & ((30'd1 << (rsh6 - 5'd1)) - 30'd1))) | r_st;
            n_qr  = {1'b0, kept6} + 25'(g6 & (st6 | kept6[0]));
        end
        n_fe = 9'(int'(r_em5) - 58 - int'(i_cfg.span_sh) + int'(rsh6));
    end

    always_ff @(posedge i_clk) begin
        if (i_load[6]) begin
            r_qr    <= n_qr;
            r_fe    <= n_fe;
            r_zero6 <= r_zero5;
        end
    end

    // stage 7: truncate to integer and saturate
    logic [8:0]  nfe;
    logic [33:0] v7;
    logic [15:0] n_code;
    logic [15:0] r_code;

    always_comb begin
        nfe = 9'(-r_fe);
        v7  = '0;
        if (r_zero6) begin
            v7 = '0;
        end else if (r_fe > 9'sd8) begin
            v7 = 34'(i_cfg.top);
        end else if (r_fe >= 9'sd0) begin
            v7 = 34'(r_qr) << r_fe[3:0];
        end else if (nfe > 9'd25) begin
            v7 = '0;
        end else begin
            v7 = 34'(r_qr) >> nfe[4:0];
        end
        if (v7 >= 34'(i_cfg.top)) begin
            n_code = i_cfg.top;
        end else begin
            n_code = v7[15:0] & i_cfg.top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[7]) r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

`default_nettype wire

// ===== rtl/core/motor_can_command_frame_encoder_core.sv =====
// pipeline: eight register stages from the input transfer to the result
// throughput: one item per cycle while i_stall is low; eight register stages hold up to eight items
// stalled result stays in the last stage while empty stages still take input
// reset: synchronous, active low, clears all stage valid flags
`default_nettype none

module motor_can_command_frame_encoder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_func,
    input  wire  [10:0] i_motor_id,
    input  wire  [31:0] i_position_bits,
    input  wire  [31:0] i_velocity_bits,
    input  wire  [31:0] i_stiffness_bits,
    input  wire  [31:0] i_damping_bits,
    input  wire  [31:0] i_torque_bits,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [10:0] o_frame_identifier,
    output logic [7:0]  o_byte0,
    output logic [7:0]  o_byte1,
    output logic [7:0]  o_byte2,
    output logic [7:0]  o_byte3,
    output logic [7:0]  o_byte4,
    output logic [7:0]  o_byte5,
    output logic [7:0]  o_byte6,
    output logic [7:0]  o_byte7
);
    import mcfe_pkg::*;

    // stage load enables, a stage loads when empty or draining
    logic [NST:0]   load;
    logic [NST-1:0] r_vld;

    always_comb begin
        load[NST] = !i_stall;
        for (int k = NST - 1; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
    end

    assign o_stall = !load[0];
    assign o_valid = r_vld[NST-1];

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (load[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (load[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // identifier and raw frame data for the non-quantized modes
    t_side n_side;
    t_side r_side [NST];

    always_comb begin
        n_side.mit  = 1'b0;
        n_side.id   = i_motor_id;
        n_side.data = '0;
        case (i_func)
            FN_POSVEL: begin
                n_side.id = i_motor_id + ID_OFS_POSVEL;
                for (int k = 0; k < 4; k++) begin
                    n_side.data[k]   = i_position_bits[8*k +: 8];
                    n_side.data[k+4] = i_velocity_bits[8*k +: 8];
                end
            end
            FN_VEL: begin
                n_side.id = i_motor_id + ID_OFS_VEL;
                for (int k = 0; k < 4; k++) begin
                    n_side.data[k] = i_velocity_bits[8*k +: 8];
                end
            end
            FN_ENABLE, FN_DISABLE, FN_ZERO: begin
                for (int k = 0; k < 7; k++) begin
                    n_side.data[k] = CMD_FILL;
                end
                if (i_func == FN_ENABLE) begin
                    n_side.data[7] = CMD_ENABLE;
                end else if (i_func == FN_DISABLE) begin
                    n_side.data[7] = CMD_DISABLE;
                end else begin
                    n_side.data[7] = CMD_ZERO;
                end
            end
            default: begin
                n_side.mit = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load[0]) r_side[0] <= n_side;
        for (int k = 1; k < NST; k++) begin
            if (load[k]) r_side[k] <= r_side[k-1];
        end
    end

    // quantizers for the mit-mode fields
    logic [15:0] pc;
    logic [15:0] vc;
    logic [15:0] kp;
    logic [15:0] kd;
    logic [15:0] tc;

    mcfe_quant u_q_pos (.i_clk(i_clk), .i_cfg(QC_POS), .i_load(load[NST-1:0]),
                        .i_bits(i_position_bits), .o_code(pc));
    mcfe_quant u_q_vel (.i_clk(i_clk), .i_cfg(QC_VEL), .i_load(load[NST-1:0]),
                        .i_bits(i_velocity_bits), .o_code(vc));
    mcfe_quant u_q_kp  (.i_clk(i_clk), .i_cfg(QC_KP), .i_load(load[NST-1:0]),
                        .i_bits(i_stiffness_bits), .o_code(kp));
    mcfe_quant u_q_kd  (.i_clk(i_clk), .i_cfg(QC_KD), .i_load(load[NST-1:0]),
                        .i_bits(i_damping_bits), .o_code(kd));
    mcfe_quant u_q_tq  (.i_clk(i_clk), .i_cfg(QC_TQ), .i_load(load[NST-1:0]),
                        .i_bits(i_torque_bits), .o_code(tc));

    // frame assembly
    always_comb begin
        o_frame_identifier = r_side[NST-1].id;
        if (r_side[NST-1].mit) begin
            o_byte0 = pc[15:8];
            o_byte1 = pc[7:0];
            o_byte2 = vc[11:4];
            o_byte3 = {vc[3:0], kp[11:8]};
            o_byte4 = kp[7:0];
            o_byte5 = kd[11:4];
            o_byte6 = {kd[3:0], tc[11:8]};
            o_byte7 = tc[7:0];
        end else begin
            o_byte0 = r_side[NST-1].data[0];
            o_byte1 = r_side[NST-1].data[1];
            o_byte2 = r_side[NST-1].data[2];
            o_byte3 = r_side[NST-1].data[3];
            o_byte4 = r_side[NST-1].data[4];
            o_byte5 = r_side[NST-1].data[5];
            o_byte6 = r_side[NST-1].data[6];
            o_byte7 = r_side[NST-1].data[7];
        end
    end

    // input is held off only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // an input transfer fills the first stage
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("input transfer lost");

    // reset empties the pipeline
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("stage valid flags not cleared by reset");

endmodule

`default_nettype wire
